// ----- rtl/sitdc_pkg.sv -----
// Shared constants and types for the signed integer to decimal character unit.
package sitdc_pkg;

    localparam int BIN_W       = 32;
    localparam int DIGIT_W     = 4;
    localparam int NUM_DIGITS  = 10;
    localparam int BCD_W       = NUM_DIGITS * DIGIT_W;
    localparam int CONV_CNT_W  = $clog2(BIN_W);
    localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS);
    localparam int CODE_W      = 6;

    localparam logic [CODE_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CODE_W-1:0] CHAR_NINE  = 6'd57;
    localparam logic [CODE_W-1:0] CHAR_MINUS = 6'd45;

    typedef struct packed {
        logic load;
        logic dabble;
        logic digit_shift;
    } dabble_ctrl_t;

endpackage

// ----- rtl/sitdc_dabble.sv -----
// Bit-serial binary to BCD converter (shift and add three), with digit unload.
module sitdc_dabble (
    input  logic                                clk,
    input  logic [sitdc_pkg::BIN_W-1:0]         mag,
    input  sitdc_pkg::dabble_ctrl_t             ctrl,
    output logic [sitdc_pkg::DIGIT_W-1:0]       top_digit
);

    logic [sitdc_pkg::BIN_W-1:0] bin_reg;
    logic [sitdc_pkg::BIN_W-1:0] bin_next;
    logic [sitdc_pkg::BCD_W-1:0] bcd_reg;
    logic [sitdc_pkg::BCD_W-1:0] bcd_next;
    logic [sitdc_pkg::BCD_W-1:0] bcd_adj;

    // every digit of 5 or more gets 3 added before the next shift
    always_comb
    begin
        for (int d = 0; d < sitdc_pkg::NUM_DIGITS; d++)
        begin
            if (bcd_reg[d*sitdc_pkg::DIGIT_W +: sitdc_pkg::DIGIT_W] >= 4'd5)
                bcd_adj[d*sitdc_pkg::DIGIT_W +: sitdc_pkg::DIGIT_W] =
                    bcd_reg[d*sitdc_pkg::DIGIT_W +: sitdc_pkg::DIGIT_W] + 4'd3;
            else
                bcd_adj[d*sitdc_pkg::DIGIT_W +: sitdc_pkg::DIGIT_W] =
                    bcd_reg[d*sitdc_pkg::DIGIT_W +: sitdc_pkg::DIGIT_W];
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        if (ctrl.load)
        begin
            bin_next = mag;
            bcd_next = '0;
        end
        else if (ctrl.dabble)
        begin
            bin_next = {bin_reg[sitdc_pkg::BIN_W-2:0], 1'b0};
            bcd_next = {bcd_adj[sitdc_pkg::BCD_W-2:0], bin_reg[sitdc_pkg::BIN_W-1]};
        end
        else if (ctrl.digit_shift)
        begin
            bcd_next = {bcd_reg[sitdc_pkg::BCD_W-sitdc_pkg::DIGIT_W-1:0],
                        {sitdc_pkg::DIGIT_W{1'b0}}};
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign top_digit = bcd_reg[sitdc_pkg::BCD_W-1 -: sitdc_pkg::DIGIT_W];

endmodule

// ----- rtl/signed_int_to_decimal_chars_unit.sv -----
// Top level: signed 32-bit integer to decimal ASCII characters, one per strobe.
//
//  channel   | handshake           | payload
//  ----------+---------------------+---------------------------
//  request   | start / busy        | value[31:0] (signed)
//  result    | strobe (one cycle)  | char_code[5:0], last_char
//
// A request is loaded at the accepting edge, then converted by shift/add-3 (one bit
// per cycle), followed by a minus sign if negative and a scan of all 10 digits,
// so how long busy stays high does not depend on the magnitude.
// Leading-zero digits are scanned but give no strobe.
// Reset clears the sequencer and the strobe; the receiver cannot stall.
module signed_int_to_decimal_chars_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [sitdc_pkg::BIN_W-1:0] value,
    output logic                               busy,
    output logic                               strobe,
    output logic [sitdc_pkg::CODE_W-1:0]       char_code,
    output logic                               last_char
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CONV   = 2'd1;
    localparam logic [1:0] S_SIGN   = 2'd2;
    localparam logic [1:0] S_DIGITS = 2'd3;

    logic [1:0]                          state_reg;
    logic [1:0]                          state_next;
    logic [sitdc_pkg::CONV_CNT_W-1:0]    conv_cnt_reg;
    logic [sitdc_pkg::CONV_CNT_W-1:0]    conv_cnt_next;
    logic [sitdc_pkg::DIGIT_CNT_W-1:0]   digit_cnt_reg;
    logic [sitdc_pkg::DIGIT_CNT_W-1:0]   digit_cnt_next;
    logic                                neg_reg;
    logic                                neg_next;
    logic                                started_reg;
    logic                                started_next;
    logic                                strobe_reg;
    logic                                strobe_next;
    logic [sitdc_pkg::CODE_W-1:0]        char_code_reg;
    logic [sitdc_pkg::CODE_W-1:0]        char_code_next;
    logic                                last_reg;
    logic                                last_next;

    logic [sitdc_pkg::BIN_W-1:0]         value_u;
    logic [sitdc_pkg::BIN_W-1:0]         mag;
    logic                                accept;
    logic                                last_digit;
    logic [sitdc_pkg::DIGIT_W-1:0]       top_digit;
    sitdc_pkg::dabble_ctrl_t             ctrl;

    assign value_u = value;
    // unsigned negate keeps the most negative value exact
    assign mag     = value_u[sitdc_pkg::BIN_W-1] ? (~value_u + 32'd1) : value_u;
    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign last_digit = (digit_cnt_reg == sitdc_pkg::DIGIT_CNT_W'(sitdc_pkg::NUM_DIGITS - 1));

    always_comb
    begin
        ctrl.load        = accept;
        ctrl.dabble      = (state_reg == S_CONV);
        ctrl.digit_shift = (state_reg == S_DIGITS);
    end

    sitdc_dabble u_dabble (
        .clk       (clk),
        .mag       (mag),
        .ctrl      (ctrl),
        .top_digit (top_digit)
    );

    always_comb
    begin
        state_next     = state_reg;
        conv_cnt_next  = conv_cnt_reg;
        digit_cnt_next = digit_cnt_reg;
        neg_next       = neg_reg;
        started_next   = started_reg;
        strobe_next    = 1'b0;
        char_code_next = char_code_reg;
        last_next      = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    neg_next      = value_u[sitdc_pkg::BIN_W-1];
                    conv_cnt_next = '0;
                    state_next    = S_CONV;
                end
            end
            S_CONV:
            begin
                conv_cnt_next = conv_cnt_reg + 1'b1;
                if (conv_cnt_reg == sitdc_pkg::CONV_CNT_W'(sitdc_pkg::BIN_W - 1))
                begin
                    digit_cnt_next = '0;
                    started_next   = 1'b0;
                    state_next     = neg_reg ? S_SIGN : S_DIGITS;
                end
            end
            S_SIGN:
            begin
                strobe_next    = 1'b1;
                char_code_next = sitdc_pkg::CHAR_MINUS;
                last_next      = 1'b0;
                state_next     = S_DIGITS;
            end
            S_DIGITS:
            begin
                digit_cnt_next = digit_cnt_reg + 1'b1;
                // skip leading zeros; the units digit always goes out
                if (started_reg || top_digit != '0 || last_digit)
                begin
                    strobe_next    = 1'b1;
                    char_code_next = sitdc_pkg::CHAR_ZERO + {2'b00, top_digit};
                    last_next      = last_digit;
                end
                started_next = started_reg || (top_digit != '0);
                if (last_digit)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            conv_cnt_reg  <= '0;
            digit_cnt_reg <= '0;
            neg_reg       <= 1'b0;
            started_reg   <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            conv_cnt_reg  <= conv_cnt_next;
            digit_cnt_reg <= digit_cnt_next;
            neg_reg       <= neg_next;
            started_reg   <= started_next;
            strobe_reg    <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_code_reg <= char_code_next;
        last_reg      <= last_next;
    end

    assign strobe    = strobe_reg;
    assign char_code = char_code_reg;
    assign last_char = last_reg;

`ifndef SYNTHESIS
    a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> ($past(state_reg) == S_SIGN || $past(state_reg) == S_DIGITS))
        else $error("strobe without sign or digit phase");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (char_code == sitdc_pkg::CHAR_MINUS ||
                    (char_code >= sitdc_pkg::CHAR_ZERO && char_code <= sitdc_pkg::CHAR_NINE)))
        else $error("character code out of range");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && char_code == sitdc_pkg::CHAR_MINUS) |-> !last_char)
        else $error("minus sign flagged as last");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_char) |-> !busy)
        else $error("last character while still busy");
`endif

endmodule
